@@ rtl/core/fmrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fmrc_pkg: shared types and constants of the first-match rule classifier
// Operation, status and sequencer codes, the stored rule record and the
// result record.
// ----------------------------------------------------------------------------
package fmrc_pkg;

    localparam int RULE_SLOTS_DEF = 16;

    // Output field width of the reported slot index
    localparam int MATCH_SLOT_W = 4;

    typedef enum logic [1:0] {
        OP_EVAL   = 2'd0,
        OP_APPEND = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_READY = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } fsm_t;

    localparam logic [1:0] ACT_DONT_MEASURE = 2'd2;

    // Condition mask bit positions
    localparam int C_EVENT   = 0;
    localparam int C_UUID    = 1;
    localparam int C_SYSCALL = 2;
    localparam int C_TARGET  = 3;
    localparam int C_COMMAND = 4;

    // Packed so that the last field sits in the lowest bits, as on tdata
    typedef struct packed {
        logic [31:0] command_number;
        logic [31:0] syscall_number;
        logic [63:0] target_lo;
        logic [63:0] target_hi;
        logic [63:0] uuid_lo;
        logic [63:0] uuid_hi;
        logic [2:0]  evt_code;
        logic [4:0]  cond_mask;
        logic [1:0]  rule_action;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    typedef struct packed {
        logic [MATCH_SLOT_W-1:0] match_slot;
        logic                    matched;
        logic [1:0]              verdict;
        status_t                 status;
    } result_t;

endpackage : fmrc_pkg
`default_nettype wire

@@ rtl/core/fmrc_rule_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fmrc_rule_store: rule table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fmrc_rule_store #(
    parameter int SLOTS  = fmrc_pkg::RULE_SLOTS_DEF,
    parameter int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire fmrc_pkg::rule_t     wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output fmrc_pkg::rule_t          rd_data
);

    fmrc_pkg::rule_t mem [SLOTS];
    fmrc_pkg::rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : fmrc_rule_store
`default_nettype wire

@@ rtl/core/fmrc_match_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fmrc_match_unit: shared masked rule comparator
// Checks one stored rule against the held event; every enabled condition
// must agree.
// ----------------------------------------------------------------------------
module fmrc_match_unit (
    input  wire fmrc_pkg::rule_t rule,
    input  wire fmrc_pkg::rule_t evt,
    output logic                 hit
);

    logic ev_ok, uuid_ok, sys_ok, tgt_ok, cmd_ok;

    always_comb
    begin
        ev_ok   = !rule.cond_mask[fmrc_pkg::C_EVENT] || (rule.evt_code == evt.evt_code);
        uuid_ok = !rule.cond_mask[fmrc_pkg::C_UUID] ||
                  ((rule.uuid_hi == evt.uuid_hi) && (rule.uuid_lo == evt.uuid_lo));
        sys_ok  = !rule.cond_mask[fmrc_pkg::C_SYSCALL] ||
                  (rule.syscall_number == evt.syscall_number);
        tgt_ok  = !rule.cond_mask[fmrc_pkg::C_TARGET] ||
                  ((rule.target_hi == evt.target_hi) && (rule.target_lo == evt.target_lo));
        // command id travels in the event's syscall field
        cmd_ok  = !rule.cond_mask[fmrc_pkg::C_COMMAND] ||
                  (rule.command_number == evt.syscall_number);
        hit     = ev_ok && uuid_ok && sys_ok && tgt_ok && cmd_ok;
    end

endmodule : fmrc_match_unit
`default_nettype wire

@@ rtl/core/first_match_rule_classifier_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_match_rule_classifier_unit: ordered first-match rule table
// Append, clear, mark-ready and evaluate operations over a table of
// RULE_SLOTS masked rules, scanned one rule per cycle.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation in s_tuser and gives exactly one
// result transfer on the m side. Append, clear and mark ready go from
// acceptance straight to the emit state, which moves the result into the
// output register. Evaluate reads the rule table one slot per cycle through
// a single memory read port and tests each rule on one shared masked
// comparator; the scan stops at the first matching slot, or after all N
// stored rules when none matches. Evaluate while not ready skips the scan
// and returns status not-ready. The block takes one operation at a
// time; s_tready is low while an operation is in flight or its result cannot
// yet move into the output register, but a result waiting on m_tready does
// not stop the next transfer being accepted. Unwritten slots are never read,
// so the table has no reset.
// ----------------------------------------------------------------------------
module first_match_rule_classifier_unit #(
    parameter int RULE_SLOTS = fmrc_pkg::RULE_SLOTS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // from bit 0: rule_action[2], cond_mask[5], evt_code[3], uuid_hi[64],
    // uuid_lo[64], target_hi[64], target_lo[64], syscall_number[32],
    // command_number[32], zero pad[6]
    input  wire logic [335:0] s_tdata,
    // from bit 0: op[2]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // from bit 0: status[2], verdict[2], matched[1], match_slot[4], zero pad[7]
    output logic [15:0]       m_tdata
);

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RULE_SLOTS);

    fmrc_pkg::fsm_t    state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ready_reg, ready_next;
    fmrc_pkg::rule_t   evt_reg, evt_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    fmrc_pkg::result_t res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    fmrc_pkg::result_t m_data_reg, m_data_next;

    fmrc_pkg::rule_t   in_rule;
    fmrc_pkg::rule_t   rd_rule;
    fmrc_pkg::op_t     in_op;
    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic              hit;

    assign in_rule = fmrc_pkg::rule_t'(s_tdata[fmrc_pkg::RULE_W-1:0]);
    assign in_op   = fmrc_pkg::op_t'(s_tuser);

    fmrc_rule_store #(
        .SLOTS  (RULE_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[SLOT_W-1:0]),
        .wr_data (in_rule),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[SLOT_W-1:0]),
        .rd_data (rd_rule)
    );

    fmrc_match_unit u_match (
        .rule (rd_rule),
        .evt  (evt_reg),
        .hit  (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmrc_pkg::S_IDLE;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        evt_reg     <= evt_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ready_next     = ready_reg;
        evt_next       = evt_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        s_tready = (state_reg == fmrc_pkg::S_IDLE);
        accept   = s_tvalid && s_tready;

        unique case (state_reg)
            fmrc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_next.status     = fmrc_pkg::STAT_OK;
                    res_next.verdict    = fmrc_pkg::ACT_DONT_MEASURE;
                    res_next.matched    = 1'b0;
                    res_next.match_slot = '0;
                    state_next          = fmrc_pkg::S_EMIT;
                    unique case (in_op)
                        fmrc_pkg::OP_EVAL:
                        begin
                            evt_next = in_rule;
                            if (!ready_reg)
                            begin
                                res_next.status = fmrc_pkg::STAT_NOT_READY;
                            end
                            else
                            begin
                                issue_next = '0;
                                state_next = fmrc_pkg::S_SCAN;
                            end
                        end
                        fmrc_pkg::OP_APPEND:
                        begin
                            if (count_reg >= FULL_COUNT)
                            begin
                                res_next.status = fmrc_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                        end
                        fmrc_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            ready_next = 1'b0;
                        end
                        fmrc_pkg::OP_READY:
                        begin
                            ready_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = fmrc_pkg::S_EMIT;
                        end
                    endcase
                end
            end

            fmrc_pkg::S_SCAN:
            begin
                // read slot issue_reg while comparing the slot read last cycle
                priority if (cmp_valid_reg && hit)
                begin
                    res_next.verdict    = rd_rule.rule_action;
                    res_next.matched    = 1'b1;
                    res_next.match_slot = fmrc_pkg::MATCH_SLOT_W'(cmp_idx_reg);
                    state_next          = fmrc_pkg::S_EMIT;
                end
                else if (issue_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    issue_next     = CNT_W'(issue_reg + 1'b1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[SLOT_W-1:0];
                end
                else
                begin
                    // table exhausted: default verdict stands
                    state_next = fmrc_pkg::S_EMIT;
                end
            end

            fmrc_pkg::S_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = fmrc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fmrc_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

endmodule : first_match_rule_classifier_unit
`default_nettype wire
